FILE: hdl/spd_pkg.sv
// Shared types, constants and tile symmetry functions for the symmetric pattern dictionary.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int TILE_SIDE   = 2;
    localparam int SYMBOL_BITS = 16;
    localparam int TABLE_DEPTH = 256;

    localparam int NCELL = TILE_SIDE * TILE_SIDE;
    localparam int NSYM  = 8;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int EXT_W = 64 + SYMBOL_BITS;

    localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [SYMBOL_BITS-1:0] cells_t [NCELL];

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] tile;
        logic [7:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [2:0]  symmetry_index;
        logic [7:0]  entry_index;
        logic [15:0] weight;
        logic        is_new;
        logic        table_full;
        logic        bad_index;
        logic [63:0] entry_tile;
        logic [8:0]  entry_count;
        logic        last;
    } result_t;

    function automatic logic [SYMBOL_BITS-1:0] cell_at(logic [63:0] t, int k);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(t);
        if (k * SYMBOL_BITS < 64)
            return ext[k*SYMBOL_BITS +: SYMBOL_BITS];
        else
            return '0;
    endfunction

    function automatic logic [63:0] pack_cells(cells_t cells);
        logic [EXT_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < NCELL; k++)
        begin
            if (k * SYMBOL_BITS < 64)
                acc = acc | (EXT_W'(cells[k]) << (k * SYMBOL_BITS));
        end
        return acc[63:0];
    endfunction

    function automatic logic [63:0] normalize_tile(logic [63:0] t);
        cells_t cells;
        for (int k = 0; k < NCELL; k++)
            cells[k] = cell_at(t, k);
        return pack_cells(cells);
    endfunction

    function automatic logic [63:0] mirror_tile(logic [63:0] t);
        cells_t cells;
        for (int r = 0; r < TILE_SIDE; r++)
            for (int c = 0; c < TILE_SIDE; c++)
                cells[r*TILE_SIDE + c] = cell_at(t, r*TILE_SIDE + (TILE_SIDE - 1 - c));
        return pack_cells(cells);
    endfunction

    function automatic logic [63:0] turn_tile(logic [63:0] t);
        cells_t cells;
        for (int r = 0; r < TILE_SIDE; r++)
            for (int c = 0; c < TILE_SIDE; c++)
                cells[r*TILE_SIDE + c] = cell_at(t, c*TILE_SIDE + (TILE_SIDE - 1 - r));
        return pack_cells(cells);
    endfunction

endpackage

FILE: hdl/spd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/symmetric_pattern_dictionary.sv
// Top level of the symmetric pattern dictionary: command sequencer around tile and weight RAMs.
`timescale 1ns / 1ps

// An add item forms the eight dihedral symmetries of the tile and, for each,
// scans the tile RAM from entry 0 upward, one entry per cycle through its single
// read port, and yields eight results, one per symmetry, spaced by those scans.
// A read item and a clear item each yield one result. busy is high while an
// item is in work; each result is shown for exactly one cycle with done high,
// and the receiver must take it then. Command 3 is ignored and yields no result.
module symmetric_pattern_dictionary
    import spd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       sym_reg, sym_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;

    logic [63:0]      even_reg, even_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [7:0]       rd_index_reg, rd_index_next;
    logic             bad_reg, bad_next;
    result_t          result_reg, result_next;

    logic             tile_we, weight_we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [15:0]      weight_wdata, weight_rdata, weight_inc;
    logic [63:0]      tile_rdata, sym_tile;
    logic             match, scan_more, is_full, read_ok;

    spd_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (waddr),
        .wdata (sym_tile),
        .raddr (raddr),
        .rdata (tile_rdata)
    );

    spd_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (weight_we),
        .waddr (waddr),
        .wdata (weight_wdata),
        .raddr (raddr),
        .rdata (weight_rdata)
    );

    assign sym_tile   = sym_reg[0] ? mirror_tile(even_reg) : even_reg;
    assign match      = cmp_valid_reg && (tile_rdata == sym_tile);
    assign scan_more  = scan_reg < count_reg;
    assign is_full    = count_reg == CNT_W'(TABLE_DEPTH);
    assign weight_inc = (weight_rdata == WEIGHT_MAX) ? weight_rdata : weight_rdata + 16'd1;
    assign read_ok    = {{CNT_W{1'b0}}, item.read_index} < {8'd0, count_reg};
    assign raddr      = (state_reg == ST_IDLE) ? IDX_W'(item.read_index)
                                               : scan_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        count_next     = count_reg;
        done_next      = 1'b0;
        even_next      = even_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_index_next  = rd_index_reg;
        bad_next       = bad_reg;
        result_next    = result_reg;
        tile_we        = 1'b0;
        weight_we      = 1'b0;
        waddr          = cmp_idx_reg;
        weight_wdata   = weight_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.command)
                        CMD_ADD:
                        begin
                            even_next  = normalize_tile(item.tile);
                            sym_next   = '0;
                            scan_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        CMD_READ:
                        begin
                            rd_index_next = item.read_index;
                            bad_next      = !read_ok;
                            state_next    = ST_READ;
                        end
                        CMD_CLEAR:
                        begin
                            count_next       = '0;
                            done_next        = 1'b1;
                            result_next      = '0;
                            result_next.last = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if (match || !scan_more)
                begin
                    result_next                = '0;
                    result_next.symmetry_index = sym_reg;
                    result_next.last           = (sym_reg == 3'(NSYM - 1));
                    if (match)
                    begin
                        weight_we                = 1'b1;
                        result_next.entry_index  = 8'(cmp_idx_reg);
                        result_next.weight       = weight_inc;
                        result_next.entry_tile   = sym_tile;
                        result_next.entry_count  = 9'(count_reg);
                    end
                    else if (is_full)
                    begin
                        result_next.table_full  = 1'b1;
                        result_next.entry_count = 9'(count_reg);
                    end
                    else
                    begin
                        tile_we                 = 1'b1;
                        weight_we               = 1'b1;
                        waddr                   = count_reg[IDX_W-1:0];
                        weight_wdata            = 16'd1;
                        count_next              = count_reg + 1'b1;
                        result_next.entry_index = 8'(count_reg);
                        result_next.weight      = 16'd1;
                        result_next.is_new      = 1'b1;
                        result_next.entry_tile  = sym_tile;
                        result_next.entry_count = 9'(count_reg + 1'b1);
                    end
                    done_next = 1'b1;
                    scan_next = '0;
                    if (sym_reg == 3'(NSYM - 1))
                        state_next = ST_IDLE;
                    else
                    begin
                        sym_next = sym_reg + 3'd1;
                        if (sym_reg[0])
                            even_next = turn_tile(even_reg);
                    end
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                result_next             = '0;
                result_next.entry_index = rd_index_reg;
                result_next.bad_index   = bad_reg;
                result_next.weight      = bad_reg ? 16'd0 : weight_rdata;
                result_next.entry_tile  = bad_reg ? 64'd0 : tile_rdata;
                result_next.entry_count = 9'(count_reg);
                result_next.last        = 1'b1;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sym_reg       <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_reg       <= sym_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        even_reg     <= even_next;
        cmp_idx_reg  <= cmp_idx_next;
        rd_index_reg <= rd_index_next;
        bad_reg      <= bad_next;
        result_reg   <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/spd_checker.sv
// Port-level assertions for the symmetric pattern dictionary, bound to the top level.
`timescale 1ns / 1ps

module spd_checker
    import spd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input item_t   item,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_CLEAR
        |=> done && result.last && result.entry_count == 9'd0)
        else $error("clear item did not give an empty final result");

    a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_READ
        |=> busy ##1 (done && result.last && !busy))
        else $error("read item result not delivered two cycles after accept");

    a_new_weight: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_new |-> result.weight == 16'd1 && !result.table_full)
        else $error("inserted entry without unit weight or with full flag");

    a_add_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("non-final result shown while idle");

endmodule

bind symmetric_pattern_dictionary spd_checker u_spd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);
